[rtl/integer_to_ascii_formatter_defines.svh]
// assertion macros for the formatter top level
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define I2A_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define I2A_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/i2a_pkg.sv]
`default_nettype none

package i2a_pkg;

	// raw argument width
	localparam int VALUE_W = 64;

	// character counter width, covers the largest supported field width
	localparam int CNT_W = 7;
	// digit count width, covers the largest supported digit store
	localparam int ND_W = 6;

	// conversion kinds
	localparam logic [2:0] T_SDEC = 3'd0;
	localparam logic [2:0] T_UDEC = 3'd1;
	localparam logic [2:0] T_OCT  = 3'd2;
	localparam logic [2:0] T_HEXL = 3'd3;
	localparam logic [2:0] T_HEXU = 3'd4;
	localparam logic [2:0] T_PTR  = 3'd5;

	// argument sizes
	localparam logic [1:0] SZ_32 = 2'd0;
	localparam logic [1:0] SZ_8  = 2'd1;
	localparam logic [1:0] SZ_16 = 2'd2;
	localparam logic [1:0] SZ_64 = 2'd3;

	// flag bit positions
	localparam int FLAG_PLUS = 0;
	localparam int FLAG_ALT  = 1;
	localparam int FLAG_ZERO = 2;

	// characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;

	// length of the null pointer text
	localparam logic [CNT_W-1:0] NIL_LEN = 7'd5;

	typedef enum logic [1:0] {
		RADIX_DEC,
		RADIX_OCT,
		RADIX_HEX
	} radix_t;

	// character layout of one conversion
	typedef struct packed {
		logic             nil;
		logic             has_sign;
		logic [7:0]       sign_ch;
		logic [1:0]       pre_len;
		logic [7:0]       pre1_ch;
		logic             upper;
		logic [CNT_W-1:0] pad_sp;
		logic [CNT_W-1:0] pad_z;
		logic [CNT_W-1:0] zeros;
		logic [CNT_W-1:0] total;
		logic [ND_W-1:0]  nd;
	} plan_t;

	// digit value to its character
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] ch;
		if (d < 4'd10) begin
			ch = {4'h3, d};
		end else if (upper) begin
			ch = 8'(8'h41 + {4'h0, d} - 8'd10);
		end else begin
			ch = 8'(8'h61 + {4'h0, d} - 8'd10);
		end
		return ch;
	endfunction

	// null pointer text by position
	function automatic logic [7:0] nil_char(input logic [2:0] k);
		logic [7:0] ch;
		case (k)
			3'd0: ch = 8'h28;
			3'd1: ch = 8'h6e;
			3'd2: ch = 8'h69;
			3'd3: ch = 8'h6c;
			default: ch = 8'h29;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

[rtl/i2a_digits.sv]
`default_nettype none

module i2a_digits #(
	parameter int DIGIT_SLOTS = 24
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire i2a_pkg::radix_t                radix,
	input  wire logic [i2a_pkg::VALUE_W-1:0]    mag,
	input  wire logic [$clog2(DIGIT_SLOTS)-1:0] rd_idx,
	output logic [3:0]                          rd_digit,
	output logic                                done,
	output logic [$clog2(DIGIT_SLOTS+1)-1:0]    nd
);

	localparam int NDW    = $clog2(DIGIT_SLOTS + 1);
	localparam int STEPS  = i2a_pkg::VALUE_W / 2;
	localparam int STEP_W = $clog2(STEPS);

	typedef enum logic [1:0] {
		D_IDLE,
		D_DABBLE,
		D_COUNT
	} dstate_t;

	dstate_t                     state_q;
	logic [STEP_W-1:0]           step_q;
	logic [i2a_pkg::VALUE_W-1:0] bin_q;
	logic                        done_q;
	logic [NDW-1:0]              nd_q;
	logic [3:0]                  lane_q [DIGIT_SLOTS];

	logic [3:0]                  dab_lane [DIGIT_SLOTS];
	logic [3:0]                  ld_lane [DIGIT_SLOTS];
	logic [NDW-1:0]              enc;

	// shift-and-adjust unit, two binary bits per pass
	always_comb begin
		logic [i2a_pkg::VALUE_W-1:0] b;
		b = bin_q;
		for (int i = 0; i < DIGIT_SLOTS; i++) begin
			dab_lane[i] = lane_q[i];
		end
		for (int s = 0; s < 2; s++) begin
			for (int i = 0; i < DIGIT_SLOTS; i++) begin
				if (dab_lane[i] >= 4'd5) begin
					dab_lane[i] = 4'(dab_lane[i] + 4'd3);
				end
			end
			for (int i = DIGIT_SLOTS - 1; i > 0; i--) begin
				dab_lane[i] = {dab_lane[i][2:0], dab_lane[i-1][3]};
			end
			dab_lane[0] = {dab_lane[0][2:0], b[i2a_pkg::VALUE_W-1]};
			b = b << 1;
		end
	end

	// octal and hex digits are plain bit fields of the magnitude
	always_comb begin
		for (int i = 0; i < DIGIT_SLOTS; i++) begin
			if (radix == i2a_pkg::RADIX_HEX) begin
				ld_lane[i] = 4'(mag >> (4 * i));
			end else begin
				ld_lane[i] = {1'b0, 3'(mag >> (3 * i))};
			end
		end
	end

	// digit count from the highest nonzero lane, at least one
	always_comb begin
		enc = NDW'(1);
		for (int i = 1; i < DIGIT_SLOTS; i++) begin
			if (lane_q[i] != 4'd0) begin
				enc = NDW'(i + 1);
			end
		end
	end

	// digit store
	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < DIGIT_SLOTS; i++) begin
				lane_q[i] <= (radix == i2a_pkg::RADIX_DEC) ? 4'd0 : ld_lane[i];
			end
		end else if (state_q == D_DABBLE) begin
			for (int i = 0; i < DIGIT_SLOTS; i++) begin
				lane_q[i] <= dab_lane[i];
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			step_q  <= '0;
			bin_q   <= '0;
			done_q  <= 1'b0;
			nd_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						bin_q   <= mag;
						step_q  <= '0;
						state_q <= (radix == i2a_pkg::RADIX_DEC) ? D_DABBLE : D_COUNT;
					end
				end
				D_DABBLE: begin
					bin_q  <= bin_q << 2;
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(STEPS - 1)) begin
						state_q <= D_COUNT;
					end
				end
				D_COUNT: begin
					nd_q    <= enc;
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign rd_digit = lane_q[rd_idx];
	assign done     = done_q;
	assign nd       = nd_q;

endmodule

`default_nettype wire

[rtl/i2a_emit.sv]
`default_nettype none

module i2a_emit #(
	parameter int DIGIT_SLOTS = 24
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire i2a_pkg::plan_t                 plan,
	output logic [$clog2(DIGIT_SLOTS)-1:0]      rd_idx,
	input  wire logic [3:0]                     rd_digit,
	output logic                                busy,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [7:0]                          m_tdata,
	output logic                                m_tlast
);

	localparam int IDX_W = $clog2(DIGIT_SLOTS);
	localparam int CW    = i2a_pkg::CNT_W;

	typedef enum logic [3:0] {
		P_IDLE,
		P_SPACE,
		P_SIGN,
		P_PRE0,
		P_PRE1,
		P_ZPAD,
		P_ZEROS,
		P_DIGITS,
		P_NIL
	} phase_t;

	phase_t         phase_q;
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  rem_q;
	logic [IDX_W-1:0] idx_q;
	i2a_pkg::plan_t plan_q;
	logic           out_valid_q;
	logic [7:0]     out_char_q;
	logic           out_last_q;

	logic           can_load;
	logic           ld_char;
	logic [7:0]     cur_char;
	phase_t         next_phase;
	logic [CW-1:0]  next_cnt;

	assign can_load = !out_valid_q || m_tready;

	// a character moves into the output register this cycle
	assign ld_char = !start && (phase_q != P_IDLE) && (cnt_q != '0) && can_load;

	// character of the current segment
	always_comb begin
		case (phase_q)
			P_SPACE:  cur_char = i2a_pkg::CH_SPACE;
			P_SIGN:   cur_char = plan_q.sign_ch;
			P_PRE0:   cur_char = i2a_pkg::CH_ZERO;
			P_PRE1:   cur_char = plan_q.pre1_ch;
			P_ZPAD:   cur_char = i2a_pkg::CH_ZERO;
			P_ZEROS:  cur_char = i2a_pkg::CH_ZERO;
			P_DIGITS: cur_char = i2a_pkg::digit_char(rd_digit, plan_q.upper);
			P_NIL:    cur_char = i2a_pkg::nil_char(3'(i2a_pkg::NIL_LEN - cnt_q));
			default:  cur_char = i2a_pkg::CH_SPACE;
		endcase
	end

	// segment order: spaces, sign, prefix, zero pad, precision zeros, digits; a null pointer has spaces, then its text
	always_comb begin
		case (phase_q)
			P_SPACE: begin
				next_phase = plan_q.nil ? P_NIL : P_SIGN;
				next_cnt   = plan_q.nil ? i2a_pkg::NIL_LEN : CW'(plan_q.has_sign);
			end
			P_SIGN: begin
				next_phase = P_PRE0;
				next_cnt   = CW'(plan_q.pre_len != 2'd0);
			end
			P_PRE0: begin
				next_phase = P_PRE1;
				next_cnt   = CW'(plan_q.pre_len == 2'd2);
			end
			P_PRE1: begin
				next_phase = P_ZPAD;
				next_cnt   = plan_q.pad_z;
			end
			P_ZPAD: begin
				next_phase = P_ZEROS;
				next_cnt   = plan_q.zeros;
			end
			P_ZEROS: begin
				next_phase = P_DIGITS;
				next_cnt   = CW'(plan_q.nd);
			end
			default: begin
				next_phase = P_IDLE;
				next_cnt   = '0;
			end
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= P_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			idx_q       <= '0;
			plan_q      <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && !ld_char) begin
				out_valid_q <= 1'b0;
			end
			if (start) begin
				plan_q  <= plan;
				phase_q <= P_SPACE;
				cnt_q   <= plan.pad_sp;
				rem_q   <= plan.total;
			end else if (phase_q != P_IDLE) begin
				if (cnt_q == '0) begin
					phase_q <= next_phase;
					cnt_q   <= next_cnt;
					if (next_phase == P_DIGITS) begin
						idx_q <= IDX_W'(plan_q.nd - 1'b1);
					end
				end else if (can_load) begin
					out_valid_q <= 1'b1;
					out_char_q  <= cur_char;
					out_last_q  <= (rem_q == CW'(1));
					cnt_q       <= cnt_q - 1'b1;
					rem_q       <= rem_q - 1'b1;
					idx_q       <= idx_q - 1'b1;
					if (rem_q == CW'(1)) begin
						phase_q <= P_IDLE;
					end
				end
			end
		end
	end

	assign rd_idx   = idx_q;
	assign busy     = (phase_q != P_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

[rtl/integer_to_ascii_formatter.sv]
// channel  dir  signals                          contents
// s_       in   tvalid tready tdata[79:0]        one conversion request
//                                 tuser[4:0]
// m_       out  tvalid tready tdata[7:0] tlast   one character, tlast on the final one
//
// a request is taken only while the block is idle; then the digit unit runs:
// 32 shift-and-adjust passes for decimal, a single load for octal, hex and pointer.
// the emitter starts once the digit unit is done and the layout is captured, then sends
// one character per cycle while m_tready is high, pausing at each segment change.
// arst_n clears all control; a stalled m_ channel holds the output register and
// the emitter waits, the last character may still wait when the next request is taken.
`default_nettype none

`include "integer_to_ascii_formatter_defines.svh"

module integer_to_ascii_formatter #(
	parameter int DIGIT_SLOTS = 24,
	parameter int MAX_WIDTH   = 60
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// value[63:0], flag_bits[66:64], min_width[72:67], min_digits[78:73], zero[79]
	input  wire logic [79:0] s_tdata,
	// req_type[2:0], size_sel[4:3]
	input  wire logic [4:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// out_char[7:0]
	output logic [7:0]       m_tdata,
	output logic             m_tlast
);

	localparam int CW    = i2a_pkg::CNT_W;
	localparam int VW    = i2a_pkg::VALUE_W;
	localparam int IDX_W = $clog2(DIGIT_SLOTS);
	localparam int NDW   = $clog2(DIGIT_SLOTS + 1);
	localparam logic [CW-1:0] WIDTH_CAP = CW'(MAX_WIDTH);
	localparam logic [CW-1:0] PREC_CAP  = CW'(MAX_WIDTH - 2);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CONV,
		S_PLAN,
		S_EMIT
	} state_t;

	state_t          state_q;
	logic            start_q;
	logic [2:0]      type_q;
	logic [2:0]      flags_q;
	logic [CW-1:0]   width_q;
	logic [CW-1:0]   prec_q;
	logic [VW-1:0]   mag_q;
	logic            neg_q;

	logic [2:0]      req_type;
	logic [1:0]      size_sel;
	logic [VW-1:0]   value;
	logic [2:0]      flag_bits;
	logic [5:0]      min_width;
	logic [5:0]      min_digits;
	logic            s_xfer;

	logic [VW-1:0]   masked;
	logic [VW-1:0]   sext;
	logic            sbit;
	logic            neg_in;
	logic [VW-1:0]   mag_in;
	logic [CW-1:0]   w_in;
	logic [CW-1:0]   p_in;

	i2a_pkg::radix_t radix;
	logic            dig_done;
	logic [NDW-1:0]  dig_nd;
	logic [IDX_W-1:0] rd_idx;
	logic [3:0]      rd_digit;

	i2a_pkg::plan_t  plan;
	logic            emit_start;
	logic            emit_busy;

	// request fields
	assign req_type   = s_tuser[2:0];
	assign size_sel   = s_tuser[4:3];
	assign value      = s_tdata[63:0];
	assign flag_bits  = s_tdata[66:64];
	assign min_width  = s_tdata[72:67];
	assign min_digits = s_tdata[78:73];

	assign s_tready = (state_q == S_IDLE);
	assign s_xfer   = s_tvalid && s_tready;

	// size truncation, sign extension and magnitude
	always_comb begin
		case (size_sel)
			i2a_pkg::SZ_8: begin
				masked = {56'b0, value[7:0]};
				sext   = {{56{value[7]}}, value[7:0]};
				sbit   = value[7];
			end
			i2a_pkg::SZ_16: begin
				masked = {48'b0, value[15:0]};
				sext   = {{48{value[15]}}, value[15:0]};
				sbit   = value[15];
			end
			i2a_pkg::SZ_32: begin
				masked = {32'b0, value[31:0]};
				sext   = {{32{value[31]}}, value[31:0]};
				sbit   = value[31];
			end
			default: begin
				masked = value;
				sext   = value;
				sbit   = value[63];
			end
		endcase
		neg_in = (req_type == i2a_pkg::T_SDEC) && sbit;
		if (req_type == i2a_pkg::T_PTR) begin
			mag_in = value;
		end else if (neg_in) begin
			mag_in = VW'(~sext + 64'd1);
		end else begin
			mag_in = masked;
		end
		w_in = (CW'(min_width) > WIDTH_CAP) ? WIDTH_CAP : CW'(min_width);
		p_in = (CW'(min_digits) > PREC_CAP) ? PREC_CAP : CW'(min_digits);
	end

	// digit base of the current request
	always_comb begin
		case (type_q)
			i2a_pkg::T_SDEC: radix = i2a_pkg::RADIX_DEC;
			i2a_pkg::T_UDEC: radix = i2a_pkg::RADIX_DEC;
			i2a_pkg::T_OCT:  radix = i2a_pkg::RADIX_OCT;
			default:         radix = i2a_pkg::RADIX_HEX;
		endcase
	end

	// layout: sign, prefix, precision zeros and padding
	always_comb begin
		logic [CW-1:0] nd_c;
		logic [CW-1:0] lead;
		logic [CW-1:0] body;
		logic [CW-1:0] pad;
		logic          mag_nz;
		logic          zpad;
		nd_c   = CW'(dig_nd);
		mag_nz = |mag_q;
		zpad   = flags_q[i2a_pkg::FLAG_ZERO] && (prec_q == '0);

		plan          = '0;
		plan.nd       = i2a_pkg::ND_W'(dig_nd);
		plan.upper    = (type_q == i2a_pkg::T_HEXU);
		plan.zeros    = (prec_q > nd_c) ? CW'(prec_q - nd_c) : '0;
		plan.has_sign = neg_q || ((type_q == i2a_pkg::T_SDEC) && flags_q[i2a_pkg::FLAG_PLUS]);
		plan.sign_ch  = neg_q ? i2a_pkg::CH_MINUS : i2a_pkg::CH_PLUS;
		plan.pre1_ch  = i2a_pkg::CH_X_LO;
		plan.pre_len  = 2'd0;
		if (type_q == i2a_pkg::T_PTR) begin
			plan.pre_len = 2'd2;
		end else if (flags_q[i2a_pkg::FLAG_ALT]) begin
			if (type_q == i2a_pkg::T_OCT) begin
				plan.pre_len = (plan.zeros == '0 && mag_nz) ? 2'd1 : 2'd0;
			end else if ((type_q == i2a_pkg::T_HEXL || type_q == i2a_pkg::T_HEXU) && mag_nz) begin
				plan.pre_len = 2'd2;
				plan.pre1_ch = (type_q == i2a_pkg::T_HEXU) ? i2a_pkg::CH_X_UP : i2a_pkg::CH_X_LO;
			end
		end
		lead = CW'(plan.has_sign) + CW'(plan.pre_len);
		body = CW'(lead + plan.zeros + nd_c);

		plan.nil = (type_q == i2a_pkg::T_PTR) && !mag_nz;
		if (plan.nil) begin
			pad         = (width_q > i2a_pkg::NIL_LEN) ? CW'(width_q - i2a_pkg::NIL_LEN) : '0;
			plan.pad_sp = pad;
			plan.pad_z  = '0;
			plan.total  = CW'(pad + i2a_pkg::NIL_LEN);
		end else begin
			pad         = (width_q > body) ? CW'(width_q - body) : '0;
			plan.pad_sp = zpad ? '0 : pad;
			plan.pad_z  = zpad ? pad : '0;
			plan.total  = CW'(pad + body);
		end
	end

	assign emit_start = (state_q == S_PLAN);

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
			type_q  <= '0;
			flags_q <= '0;
			width_q <= '0;
			prec_q  <= '0;
			mag_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_xfer && req_type <= i2a_pkg::T_PTR) begin
						type_q  <= req_type;
						flags_q <= flag_bits;
						width_q <= w_in;
						prec_q  <= p_in;
						mag_q   <= mag_in;
						neg_q   <= neg_in;
						start_q <= 1'b1;
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					if (dig_done) begin
						state_q <= S_PLAN;
					end
				end
				S_PLAN: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!emit_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	i2a_digits #(
		.DIGIT_SLOTS(DIGIT_SLOTS)
	) u_digits (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.radix    (radix),
		.mag      (mag_q),
		.rd_idx   (rd_idx),
		.rd_digit (rd_digit),
		.done     (dig_done),
		.nd       (dig_nd)
	);

	i2a_emit #(
		.DIGIT_SLOTS(DIGIT_SLOTS)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (emit_start),
		.plan     (plan),
		.rd_idx   (rd_idx),
		.rd_digit (rd_digit),
		.busy     (emit_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// checks
	`I2A_ASSERT_IMP(a_ready_idle, clk, arst_n, s_tready, !emit_busy, "ready while characters pending")
	`I2A_ASSERT_IMP(a_done_conv, clk, arst_n, dig_done, state_q == S_CONV, "digit unit done out of turn")
	`I2A_ASSERT_NEXT(a_start_busy, clk, arst_n, emit_start, emit_busy, "emitter did not start")

endmodule

`default_nettype wire
